[rtl/core/mptb_pkg.sv]
package mptb_pkg;

	// default bank shape
	localparam int SLOTS_PER_GROUP_DEF = 8;
	localparam int GROUP_COUNT_DEF     = 2;
	localparam int COUNT_WIDTH_DEF     = 26;

	// fixed field widths
	localparam int REQ_W     = 3;
	localparam int SLOT_W    = 4;
	localparam int MS_W      = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// interval in microseconds: 65535 ms * 1000 fits in 26 bits
	localparam int US_W      = 26;
	localparam int MS_TO_US  = 1000;

	// expiry reports per tick
	localparam int MAX_EXPIRY = 8;
	localparam int EXP_CNT_W  = 4;

	localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd1000;

	// request codes
	localparam logic [REQ_W-1:0] REQ_REGISTER    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_OPEN_SLOT   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLOSE_SLOT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_OPEN_GROUP  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLOSE_GROUP = 3'd4;
	localparam logic [REQ_W-1:0] REQ_TICK        = 3'd5;

	// reply status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 2'd3;

	// result kinds
	localparam logic EV_REPLY  = 1'b0;
	localparam logic EV_EXPIRY = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0 = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD1 = 1'd1;

	// commands from controller to datapath
	typedef struct packed {
		logic                capture;
		logic                div_start;
		logic                reg_commit;
		logic                slot_apply;
		logic                grp_apply;
		logic                ptr_clr;
		logic                ptr_inc;
		logic                rd_issue;
		logic                tick_write;
		logic                reply_push;
		logic [STATUS_W-1:0] reply_status;
		logic                pend_flush;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             grp_ok;
		logic             slot_ok;
		logic             free_have;
		logic             too_short;
		logic             div_busy;
		logic             en_at_ptr;
		logic             ptr_last;
		logic             expire;
		logic             pend_valid;
		logic             out_free;
	} dp_stat_t;

endpackage

[rtl/core/multiplexed_periodic_timer_bank.sv]
// Bank of periodic software timers sharing the ticks of up to two tick groups.
// Requests enter on in_valid/in_stall (req_type, group, slot, interval_ms); one
// request is taken at a time, in_stall stays high until its work is done.
// Results leave on out_valid/out_stall through a single output register: one
// reply per command, or one expiry per wrapping slot of a tick (at most eight),
// with last set on the final result of the request. A tick with no wrap and an
// unknown request give no result.
// Registration decodes, runs 26 divider steps (one quotient bit per cycle) and
// replies; group open/close walk the group's slots; a tick walks its group,
// reading and updating each enabled slot through the single-port count
// memories. A result waits in the output register while out_stall is high; the
// next request is still taken, and its own result waits for the register to
// drain. cfg_write_en/cfg_index/cfg_data write the tick period registers; the
// user must do so only while the block is idle, which it does not enforce.
// Reset clears all slot claims and enables, empties the output register and
// sets both tick periods to 1000 us.
module multiplexed_periodic_timer_bank #(
	parameter int SLOTS_PER_GROUP = mptb_pkg::SLOTS_PER_GROUP_DEF,
	parameter int GROUP_COUNT     = mptb_pkg::GROUP_COUNT_DEF,
	parameter int COUNT_WIDTH     = mptb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write_en,
	input  logic [mptb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mptb_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mptb_pkg::REQ_W-1:0]     req_type,
	input  logic                          group,
	input  logic [mptb_pkg::SLOT_W-1:0]    slot,
	input  logic [mptb_pkg::MS_W-1:0]      interval_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          event_kind,
	output logic [mptb_pkg::SLOT_W-1:0]    slot_out,
	output logic [mptb_pkg::STATUS_W-1:0]  status,
	output logic                          last
);
	import mptb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	mptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// slot state, counts, divider and output register
	mptb_dp #(
		.SLOTS_PER_GROUP (SLOTS_PER_GROUP),
		.GROUP_COUNT     (GROUP_COUNT),
		.COUNT_WIDTH     (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.group        (group),
		.slot         (slot),
		.interval_ms  (interval_ms),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.event_kind   (event_kind),
		.slot_out     (slot_out),
		.status       (status),
		.last         (last),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

[rtl/core/mptb_div.sv]
module mptb_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mptb_pkg::US_W-1:0]  dividend,
	input  logic [mptb_pkg::CFG_W-1:0] divisor,
	output logic                     busy,
	output logic [mptb_pkg::US_W-1:0]  quotient
);
	import mptb_pkg::*;

	localparam int CNT_W = $clog2(US_W + 1);

	logic [CFG_W-1:0] rem_q;
	logic [CFG_W-1:0] div_q;
	logic [US_W-1:0]  quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CFG_W:0]   shifted;
	logic             ge;
	logic [CFG_W:0]   diff;

	// one restoring step: bring down the next dividend bit
	assign shifted = {rem_q, quot_q[US_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(US_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			div_q  <= divisor;
			quot_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
			quot_q <= {quot_q[US_W-2:0], ge};
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quot_q;

endmodule

[rtl/core/mptb_ctrl.sv]
module mptb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mptb_pkg::dp_stat_t stat,
	output mptb_pkg::dp_cmd_t  cmd
);
	import mptb_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DECODE   = 8'b0000_0010,
		S_DIV      = 8'b0000_0100,
		S_GRP_WALK = 8'b0000_1000,
		S_TICK_RD  = 8'b0001_0000,
		S_TICK_UPD = 8'b0010_0000,
		S_TICK_END = 8'b0100_0000,
		S_REPLY    = 8'b1000_0000
	} state_t;

	state_t              state_q, state_d;
	logic [STATUS_W-1:0] rsp_q, rsp_d;

	// next state and datapath commands
	always_comb begin
		state_d          = state_q;
		rsp_d            = rsp_q;
		cmd              = '0;
		cmd.reply_status = rsp_q;
		in_stall         = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.req) inside
					REQ_REGISTER: begin
						if (!stat.grp_ok) begin
							rsp_d   = ST_BAD_SLOT;
							state_d = S_REPLY;
						end else if (!stat.free_have) begin
							rsp_d   = ST_NO_FREE;
							state_d = S_REPLY;
						end else if (stat.too_short) begin
							rsp_d   = ST_TOO_SHORT;
							state_d = S_REPLY;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					REQ_OPEN_SLOT, REQ_CLOSE_SLOT: begin
						state_d = S_REPLY;
						if (stat.slot_ok) begin
							cmd.slot_apply = 1'b1;
							rsp_d          = ST_OK;
						end else begin
							rsp_d = ST_BAD_SLOT;
						end
					end
					REQ_OPEN_GROUP, REQ_CLOSE_GROUP: begin
						if (stat.grp_ok) begin
							cmd.ptr_clr = 1'b1;
							rsp_d       = ST_OK;
							state_d     = S_GRP_WALK;
						end else begin
							rsp_d   = ST_BAD_SLOT;
							state_d = S_REPLY;
						end
					end
					REQ_TICK: begin
						if (stat.grp_ok) begin
							cmd.ptr_clr = 1'b1;
							state_d     = S_TICK_RD;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_DIV: begin
				if (!stat.div_busy) begin
					cmd.reg_commit = 1'b1;
					rsp_d          = ST_OK;
					state_d        = S_REPLY;
				end
			end
			S_GRP_WALK: begin
				cmd.grp_apply = 1'b1;
				if (stat.ptr_last) begin
					state_d = S_REPLY;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_TICK_RD: begin
				if (stat.en_at_ptr) begin
					cmd.rd_issue = 1'b1;
					state_d      = S_TICK_UPD;
				end else if (stat.ptr_last) begin
					state_d = S_TICK_END;
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			S_TICK_UPD: begin
				// a second expiry pushes the held one out, so it needs room
				if (!(stat.expire && stat.pend_valid && !stat.out_free)) begin
					cmd.tick_write = 1'b1;
					if (stat.ptr_last) begin
						state_d = S_TICK_END;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = S_TICK_RD;
					end
				end
			end
			S_TICK_END: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.pend_flush = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					cmd.reply_push = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_q   <= ST_OK;
		end else begin
			state_q <= state_d;
			rsp_q   <= rsp_d;
		end
	end

endmodule

[rtl/core/mptb_dp.sv]
module mptb_dp #(
	parameter int SLOTS_PER_GROUP = mptb_pkg::SLOTS_PER_GROUP_DEF,
	parameter int GROUP_COUNT     = mptb_pkg::GROUP_COUNT_DEF,
	parameter int COUNT_WIDTH     = mptb_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic [mptb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mptb_pkg::CFG_W-1:0]       cfg_data,
	input  logic [mptb_pkg::REQ_W-1:0]       req_type,
	input  logic                             group,
	input  logic [mptb_pkg::SLOT_W-1:0]      slot,
	input  logic [mptb_pkg::MS_W-1:0]        interval_ms,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic                             event_kind,
	output logic [mptb_pkg::SLOT_W-1:0]      slot_out,
	output logic [mptb_pkg::STATUS_W-1:0]    status,
	output logic                             last,
	input  mptb_pkg::dp_cmd_t                cmd,
	output mptb_pkg::dp_stat_t               stat
);
	import mptb_pkg::*;

	localparam int TOTAL = SLOTS_PER_GROUP * GROUP_COUNT;
	localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int PTR_W = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SLOTS_PER_GROUP - 1);
	localparam int CW = COUNT_WIDTH;

	logic [CFG_W-1:0]     period0_q, period1_q;
	logic [REQ_W-1:0]     req_q;
	logic                 grp_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [US_W-1:0]      us_q;
	logic [TOTAL-1:0]     used_q, en_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     alloc_q;
	logic [CW-1:0]        reload_mem [TOTAL];
	logic [CW-1:0]        run_mem [TOTAL];
	logic [CW-1:0]        reload_rd_q, run_rd_q;
	logic [EXP_CNT_W-1:0] cnt_q;
	logic                 pend_valid_q;
	logic [IDX_W-1:0]     pend_idx_q;
	logic                 out_valid_q, event_kind_q, last_q;
	logic [SLOT_W-1:0]    slot_out_q;
	logic [STATUS_W-1:0]  status_q;

	logic                   grp_ok, grp_eff, slot_in_range, slot_ok, want;
	logic [IDX_W-1:0]       cur_idx, slot_idx, free_idx;
	logic [SLOTS_PER_GROUP-1:0] grp_used;
	logic                   free_have;
	logic [PTR_W-1:0]       free_ptr;
	logic [CFG_W-1:0]       period_sel, period_eff;
	logic                   too_short;
	logic                   div_busy;
	logic [US_W-1:0]        quot;
	logic [CW-1:0]          reload_new;
	logic [CW-1:0]          run_next;
	logic                   wrap, expire, out_free, push_pend;
	logic                   run_we;
	logic [IDX_W-1:0]       run_addr;
	logic [CW-1:0]          run_data;
	logic [SLOT_W-1:0]      reply_slot;

	// group and slot addressing
	assign grp_ok        = int'(grp_q) < GROUP_COUNT;
	assign grp_eff       = grp_ok & grp_q;
	assign cur_idx       = IDX_W'(int'(grp_eff) * SLOTS_PER_GROUP + int'(ptr_q));
	assign slot_idx      = IDX_W'(slot_q);
	assign slot_in_range = int'(slot_q) < TOTAL;
	assign slot_ok       = slot_in_range && used_q[slot_idx];
	assign want          = (req_q == REQ_OPEN_SLOT) || (req_q == REQ_OPEN_GROUP);
	assign grp_used      = used_q[int'(grp_eff) * SLOTS_PER_GROUP +: SLOTS_PER_GROUP];

	// lowest free slot of the group
	always_comb begin
		free_have = 1'b0;
		free_ptr  = '0;
		for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
			if (!grp_used[i]) begin
				free_have = 1'b1;
				free_ptr  = PTR_W'(i);
			end
		end
	end
	assign free_idx = IDX_W'(int'(grp_eff) * SLOTS_PER_GROUP + int'(free_ptr));

	// tick period of the group, zero read as one
	assign period_sel = grp_eff ? period1_q : period0_q;
	assign period_eff = (period_sel == '0) ? CFG_W'(1) : period_sel;
	assign too_short  = us_q < US_W'(period_eff);

	// reload count divider
	mptb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (us_q),
		.divisor  (period_eff),
		.busy     (div_busy),
		.quotient (quot)
	);

	// saturate the quotient to the count width
	if (CW >= US_W) begin : g_nosat
		assign reload_new = CW'(quot);
	end else begin : g_sat
		assign reload_new = (|quot[US_W-1:CW]) ? {CW{1'b1}} : quot[CW-1:0];
	end

	// tick arithmetic on the fetched slot
	assign run_next  = run_rd_q + CW'(1);
	assign wrap      = run_next >= reload_rd_q;
	assign expire    = wrap && (cnt_q != EXP_CNT_W'(MAX_EXPIRY));
	assign out_free  = !out_valid_q || !out_stall;
	assign push_pend = (cmd.tick_write && expire && pend_valid_q) || cmd.pend_flush;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period0_q <= PERIOD_RESET;
			period1_q <= PERIOD_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_PERIOD0: period0_q <= cfg_data;
				CFG_PERIOD1: period1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture, interval scaled to microseconds
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			grp_q  <= group;
			slot_q <= slot;
			us_q   <= US_W'(32'(interval_ms) * 32'(MS_TO_US));
		end
		if (cmd.div_start) begin
			alloc_q <= free_idx;
		end
	end

	// used and enable marks, walk pointer, expiry tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			en_q         <= '0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.reg_commit) begin
				used_q[alloc_q] <= 1'b1;
				en_q[alloc_q]   <= 1'b0;
			end
			if (cmd.slot_apply) begin
				en_q[slot_idx] <= want;
			end
			if (cmd.grp_apply && used_q[cur_idx]) begin
				en_q[cur_idx] <= want;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.capture) begin
				cnt_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.tick_write && expire) begin
				cnt_q        <= cnt_q + EXP_CNT_W'(1);
				pend_valid_q <= 1'b1;
			end else if (cmd.pend_flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_write && expire) begin
			pend_idx_q <= cur_idx;
		end
	end

	// running count write port
	always_comb begin
		run_we   = 1'b0;
		run_addr = cur_idx;
		run_data = '0;
		if (cmd.reg_commit) begin
			run_we   = 1'b1;
			run_addr = alloc_q;
		end else if (cmd.slot_apply && (en_q[slot_idx] != want)) begin
			run_we   = 1'b1;
			run_addr = slot_idx;
		end else if (cmd.grp_apply && used_q[cur_idx]) begin
			run_we = 1'b1;
		end else if (cmd.tick_write) begin
			run_we   = 1'b1;
			run_data = wrap ? '0 : run_next;
		end
	end

	// count memories
	always_ff @(posedge clk) begin
		if (run_we) begin
			run_mem[run_addr] <= run_data;
		end
		if (cmd.reg_commit) begin
			reload_mem[alloc_q] <= reload_new;
		end
		if (cmd.rd_issue) begin
			run_rd_q    <= run_mem[cur_idx];
			reload_rd_q <= reload_mem[cur_idx];
		end
	end

	// output register
	assign reply_slot = ((req_q == REQ_REGISTER) && (cmd.reply_status == ST_OK)) ?
		SLOT_W'(alloc_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.reply_push || push_pend) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply_push) begin
			event_kind_q <= EV_REPLY;
			slot_out_q   <= reply_slot;
			status_q     <= cmd.reply_status;
			last_q       <= 1'b1;
		end else if (push_pend) begin
			event_kind_q <= EV_EXPIRY;
			slot_out_q   <= SLOT_W'(pend_idx_q);
			status_q     <= ST_OK;
			last_q       <= cmd.pend_flush;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = event_kind_q;
	assign slot_out   = slot_out_q;
	assign status     = status_q;
	assign last       = last_q;

	// status to controller
	always_comb begin
		stat            = '0;
		stat.req        = req_q;
		stat.grp_ok     = grp_ok;
		stat.slot_ok    = slot_ok;
		stat.free_have  = free_have;
		stat.too_short  = too_short;
		stat.div_busy   = div_busy;
		stat.en_at_ptr  = en_q[cur_idx];
		stat.ptr_last   = ptr_q == PTR_LAST;
		stat.expire     = expire;
		stat.pend_valid = pend_valid_q;
		stat.out_free   = out_free;
	end

	// a slot is only ever enabled once claimed
	a_en_used: assert property (@(posedge clk) disable iff (!arst_n)
		(en_q & ~used_q) == '0)
		else $error("enabled slot that is not claimed");

	// a registration claims a slot that was free
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reg_commit |-> !used_q[alloc_q])
		else $error("registration onto a claimed slot");

	// nothing is loaded over a result still waiting
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.reply_push || push_pend) |-> out_free)
		else $error("output overwritten while stalled");

	// at most eight expiries per tick
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= EXP_CNT_W'(MAX_EXPIRY))
		else $error("expiry count beyond limit");

endmodule

[tb/timer_bank_checker.sv]
module timer_bank_checker import mptb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [REQ_W-1:0]     req_type,
	input  logic                group,
	input  logic [SLOT_W-1:0]    slot,
	input  logic [MS_W-1:0]      interval_ms,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                event_kind,
	input  logic [SLOT_W-1:0]    slot_out,
	input  logic [STATUS_W-1:0]  status,
	input  logic                last,
	output int                  fail_count,
	output int                  pending_count,
	output int                  result_count,
	output int                  expiry_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPG  = SLOTS_PER_GROUP_DEF;
	localparam int BANK = SLOTS_PER_GROUP_DEF * GROUP_COUNT_DEF;
	localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;

	typedef struct packed {
		logic                kind;
		logic [SLOT_W-1:0]   slot;
		logic [STATUS_W-1:0] code;
		logic                last;
	} timer_event_t;

	// shadow copy of the bank
	logic                       slot_used_q    [BANK];
	logic                       slot_enabled_q [BANK];
	logic [COUNT_WIDTH_DEF-1:0] reload_q       [BANK];
	logic [COUNT_WIDTH_DEF-1:0] running_q      [BANK];
	logic [CFG_W-1:0]           period_q       [GROUP_COUNT_DEF];

	// results still owed by the block, oldest first
	timer_event_t awaited_events[$];
	timer_event_t head;
	int fails;
	int results;
	int expiries;

	function automatic timer_event_t make_event(input logic kind, input int sl,
			input logic [STATUS_W-1:0] code);
		timer_event_t ev;
		ev.kind = kind;
		ev.slot = SLOT_W'(sl);
		ev.code = code;
		ev.last = 1'b0;
		return ev;
	endfunction

	task automatic clear_bank();
		for (int i = 0; i < BANK; i++) begin
			slot_used_q[i]    = 1'b0;
			slot_enabled_q[i] = 1'b0;
			reload_q[i]       = '0;
			running_q[i]      = '0;
		end
		period_q[0] = PERIOD_RESET;
		period_q[1] = PERIOD_RESET;
		awaited_events.delete();
	endtask

	// update the shadow bank for one request and queue the results it owes
	task automatic apply_request(input logic [REQ_W-1:0] rq, input logic grp,
			input logic [SLOT_W-1:0] sl, input logic [MS_W-1:0] ms);
		timer_event_t burst [MAX_EXPIRY];
		int base;
		int found;
		int n;
		int s;
		logic want;
		logic [63:0] us;
		logic [63:0] per;
		logic [63:0] quot;
		base  = int'(grp) * SPG;
		found = -1;
		n     = 0;
		want  = (rq == REQ_OPEN_SLOT) || (rq == REQ_OPEN_GROUP);
		case (rq)
			REQ_REGISTER: begin
				for (int i = 0; i < SPG; i++)
					if (!slot_used_q[base + i] && found < 0) found = base + i;
				if (found < 0) begin
					burst[n] = make_event(EV_REPLY, 0, ST_NO_FREE);
					n++;
				end else begin
					us  = 64'(ms) * 64'(MS_TO_US);
					// a zero period divides as one
					per = (period_q[grp] == '0) ? 64'd1 : 64'(period_q[grp]);
					if (us < per) begin
						burst[n] = make_event(EV_REPLY, 0, ST_TOO_SHORT);
						n++;
					end else begin
						quot = us / per;
						if (quot > COUNT_MAX) quot = COUNT_MAX;
						slot_used_q[found]    = 1'b1;
						slot_enabled_q[found] = 1'b0;
						reload_q[found]       = COUNT_WIDTH_DEF'(quot);
						running_q[found]      = '0;
						burst[n] = make_event(EV_REPLY, found, ST_OK);
						n++;
					end
				end
			end
			REQ_OPEN_SLOT, REQ_CLOSE_SLOT: begin
				if (!slot_used_q[sl]) begin
					burst[n] = make_event(EV_REPLY, 0, ST_BAD_SLOT);
					n++;
				end else begin
					// only a change of state clears the count
					if (slot_enabled_q[sl] != want) begin
						slot_enabled_q[sl] = want;
						running_q[sl]      = '0;
					end
					burst[n] = make_event(EV_REPLY, 0, ST_OK);
					n++;
				end
			end
			REQ_OPEN_GROUP, REQ_CLOSE_GROUP: begin
				for (int i = 0; i < SPG; i++)
					if (slot_used_q[base + i]) begin
						slot_enabled_q[base + i] = want;
						running_q[base + i]      = '0;
					end
				burst[n] = make_event(EV_REPLY, 0, ST_OK);
				n++;
			end
			REQ_TICK: begin
				for (int i = 0; i < SPG; i++) begin
					s = base + i;
					if (slot_enabled_q[s]) begin
						running_q[s] = running_q[s] + 1'b1;
						if (running_q[s] >= reload_q[s]) begin
							running_q[s] = '0;
							if (n < MAX_EXPIRY) begin
								burst[n] = make_event(EV_EXPIRY, s, ST_OK);
								n++;
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (n > 0) burst[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) awaited_events.push_back(burst[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_bank();
			fails    = 0;
			results  = 0;
			expiries = 0;
			fail_count    <= 0;
			pending_count <= 0;
			result_count  <= 0;
			expiry_count  <= 0;
		end else begin
			// outgoing result against the oldest one owed
			if (out_valid && !out_stall) begin
				results++;
				if (event_kind == EV_EXPIRY) expiries++;
				if (awaited_events.size() == 0) begin
					fails++;
					$display("%0t: unexpected result kind %0d slot %0d status %0d last %0d",
						$time, event_kind, slot_out, status, last);
				end else begin
					head = awaited_events.pop_front();
					if (head.kind !== event_kind || head.slot !== slot_out ||
							head.code !== status || head.last !== last) begin
						fails++;
						$display("%0t: result mismatch, expected kind %0d slot %0d",
							$time, head.kind, head.slot,
							" status %0d last %0d,", head.code, head.last,
							" got kind %0d slot %0d status %0d last %0d",
							event_kind, slot_out, status, last);
					end
				end
			end
			// period writes
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_PERIOD0: period_q[0] = cfg_data;
					CFG_PERIOD1: period_q[1] = cfg_data;
					default: ;
				endcase
			end
			// incoming request
			if (in_valid && !in_stall) apply_request(req_type, group, slot, interval_ms);
			fail_count    <= fails;
			pending_count <= awaited_events.size();
			result_count  <= results;
			expiry_count  <= expiries;
		end
	end

endmodule

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mptb_pkg::*;

	localparam int CYCLE_LIMIT      = 400000;
	localparam int SETTLE_CYCLES    = 64;
	localparam int RANDOM_PER_PHASE = 58;

	// request codes the block ignores
	localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_PERIOD0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic [REQ_W-1:0]     req_type     = REQ_REGISTER;
	logic                 group        = 1'b0;
	logic [SLOT_W-1:0]    slot         = '0;
	logic [MS_W-1:0]      interval_ms  = '0;
	logic                 out_stall    = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 event_kind;
	logic [SLOT_W-1:0]    slot_out;
	logic [STATUS_W-1:0]  status;
	logic                 last;

	int fail_count;
	int pending_count;
	int result_count;
	int expiry_count;

	int cycle_count   = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int sent_count    = 0;
	int ignored_count = 0;
	logic [CFG_W-1:0] period_set [2] = '{PERIOD_RESET, PERIOD_RESET};

	multiplexed_periodic_timer_bank dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.group        (group),
		.slot         (slot),
		.interval_ms  (interval_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.slot_out     (slot_out),
		.status       (status),
		.last         (last)
	);

	timer_bank_checker bank_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.group         (group),
		.slot          (slot),
		.interval_ms   (interval_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.event_kind    (event_kind),
		.slot_out      (slot_out),
		.status        (status),
		.last          (last),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.result_count  (result_count),
		.expiry_count  (expiry_count)
	);

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// one request, with a random gap in front of it
	task automatic send_request(input logic [REQ_W-1:0] rq, input logic grp,
			input logic [SLOT_W-1:0] sl, input logic [MS_W-1:0] ms);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= rq;
		group       <= grp;
		slot        <= sl;
		interval_ms <= ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
	endtask

	// weighted mix: ticks dominate, registrations aim at short reload counts
	task automatic send_random_request(output bit counted);
		int pick;
		int span;
		logic grp;
		logic [SLOT_W-1:0] sl;
		logic [MS_W-1:0] ms;
		pick    = $urandom_range(0, 99);
		grp     = 1'($urandom_range(0, 1));
		sl      = SLOT_W'($urandom_range(0, 15));
		ms      = MS_W'($urandom);
		counted = 1'b1;
		if (pick < 45) begin
			send_request(REQ_TICK, grp, sl, ms);
		end else if (pick < 57) begin
			if ($urandom_range(0, 3) != 0) begin
				span = (period_set[grp] == '0) ? 1 : int'(period_set[grp]);
				ms   = MS_W'($urandom_range(0, span * 3 / 1000 + 2));
			end
			send_request(REQ_REGISTER, grp, sl, ms);
		end else if (pick < 70) begin
			send_request(REQ_OPEN_SLOT, grp, sl, ms);
		end else if (pick < 80) begin
			send_request(REQ_CLOSE_SLOT, grp, sl, ms);
		end else if (pick < 87) begin
			send_request(REQ_OPEN_GROUP, grp, sl, ms);
		end else if (pick < 94) begin
			send_request(REQ_CLOSE_GROUP, grp, sl, ms);
		end else begin
			send_request($urandom_range(0, 1) ? REQ_UNKNOWN_HI : REQ_UNKNOWN_LO, grp, sl, ms);
			counted = 1'b0;
			ignored_count++;
		end
	endtask

	task automatic run_random_batch(input int count);
		int done;
		bit counted;
		done = 0;
		while (done < count) begin
			send_random_request(counted);
			if (counted) done++;
		end
	endtask

	// drain every owed result, then give silent work time to finish
	task automatic settle_bank();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_periods(input logic [CFG_W-1:0] p0, input logic [CFG_W-1:0] p1);
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_PERIOD0;
		cfg_data     <= p0;
		@(posedge clk);
		cfg_index    <= CFG_PERIOD1;
		cfg_data     <= p1;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		period_set[0] = p0;
		period_set[1] = p1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bad slots, empty group, idle tick and ignored codes
		send_request(REQ_OPEN_SLOT, 1'b0, 4'd3, '0);
		send_request(REQ_CLOSE_SLOT, 1'b1, 4'd15, '0);
		send_request(REQ_OPEN_GROUP, 1'b1, '0, '0);
		send_request(REQ_TICK, 1'b0, '0, '0);
		send_request(REQ_UNKNOWN_LO, 1'b0, '0, '0);
		send_request(REQ_UNKNOWN_HI, 1'b1, 4'd15, 16'hffff);
		ignored_count += 2;
		// too short, then fill group zero with reloads of one and two
		send_request(REQ_REGISTER, 1'b0, '0, 16'd0);
		for (int i = 0; i < SLOTS_PER_GROUP_DEF; i++)
			send_request(REQ_REGISTER, 1'b0, '0, (i % 2 == 0) ? 16'd1 : 16'd2);
		send_request(REQ_REGISTER, 1'b0, '0, 16'hffff);
		send_request(REQ_REGISTER, 1'b1, '0, 16'hffff);
		// reopening an enabled slot must keep its count
		send_request(REQ_OPEN_SLOT, 1'b0, 4'd1, '0);
		send_request(REQ_TICK, 1'b0, '0, '0);
		send_request(REQ_OPEN_SLOT, 1'b0, 4'd1, '0);
		send_request(REQ_TICK, 1'b0, '0, '0);
		// whole group: four expiries, then all eight at once
		send_request(REQ_OPEN_GROUP, 1'b0, '0, '0);
		send_request(REQ_TICK, 1'b0, '0, '0);
		send_request(REQ_TICK, 1'b0, '0, '0);
		send_request(REQ_CLOSE_SLOT, 1'b0, 4'd1, '0);
		send_request(REQ_CLOSE_SLOT, 1'b0, 4'd1, '0);
		send_request(REQ_CLOSE_GROUP, 1'b0, '0, '0);
		send_request(REQ_TICK, 1'b0, '0, '0);

		run_random_batch(RANDOM_PER_PHASE);

		// extreme periods, sender mostly idle
		settle_bank();
		write_periods(16'hffff, 16'd1);
		send_idle_pct = 81;
		run_random_batch(RANDOM_PER_PHASE);

		// zero period on group one, receiver mostly stalling
		settle_bank();
		write_periods(16'd1, 16'd0);
		send_idle_pct = 0;
		stall_pct     = 81;
		run_random_batch(RANDOM_PER_PHASE);

		// random period, both sides idling
		settle_bank();
		write_periods(CFG_W'($urandom_range(1, 65535)), 16'hffff);
		send_idle_pct = 37;
		stall_pct     = 37;
		run_random_batch(RANDOM_PER_PHASE);

		settle_bank();
		$display("covered %0d requests (%0d ignored codes) over four period settings",
			sent_count, ignored_count);
		$display("checked %0d results, %0d of them expiries, %0d failures",
			result_count, expiry_count, fail_count);
		if (fail_count == 0 && pending_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/mptb_pkg.sv
rtl/core/mptb_div.sv
rtl/core/mptb_ctrl.sv
rtl/core/mptb_dp.sv
rtl/core/multiplexed_periodic_timer_bank.sv
tb/timer_bank_checker.sv
tb/testbench.sv
